// ----- design/tube_client_protocol_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// tube client protocol engine assertion macros
// implication checks that compile away in synthesis builds
// ----------------------------------------------------------------------------
`ifndef TUBE_CLIENT_PROTOCOL_ENGINE_TOP_MACROS_SVH
`define TUBE_CLIENT_PROTOCOL_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TCPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TCPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/tcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpe_pkg
// codes shared by the tube client protocol engine
// ----------------------------------------------------------------------------
package tcpe_pkg;

  // action codes reported per request
  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_RESET   = 4'd1;
  localparam logic [3:0] ACT_ESCAPE  = 4'd2;
  localparam logic [3:0] ACT_EVENT   = 4'd3;
  localparam logic [3:0] ACT_ERRCHAR = 4'd4;
  localparam logic [3:0] ACT_ERRDONE = 4'd5;
  localparam logic [3:0] ACT_STORE   = 4'd6;
  localparam logic [3:0] ACT_DISCARD = 4'd7;
  localparam logic [3:0] ACT_SEND    = 4'd8;
  localparam logic [3:0] ACT_HDRDONE = 4'd9;
  localparam logic [3:0] ACT_BADTYPE = 4'd10;

  // host register addresses
  localparam logic [2:0] REG_R1 = 3'd1;
  localparam logic [2:0] REG_R2 = 3'd3;
  localparam logic [2:0] REG_R3 = 3'd5;
  localparam logic [2:0] REG_R4 = 3'd7;

  // event machine states
  localparam logic [1:0] EV_IDLE   = 2'd0;
  localparam logic [1:0] EV_WAIT_Y = 2'd1;
  localparam logic [1:0] EV_WAIT_X = 2'd2;
  localparam logic [1:0] EV_WAIT_A = 2'd3;

  // header machine states
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ERR_ZERO = 4'd1;
  localparam logic [3:0] PH_ERR_NUM  = 4'd2;
  localparam logic [3:0] PH_ERR_STR  = 4'd3;
  localparam logic [3:0] PH_ID       = 4'd4;
  localparam logic [3:0] PH_ADDR0    = 4'd5;
  localparam logic [3:0] PH_ADDR1    = 4'd6;
  localparam logic [3:0] PH_ADDR2    = 4'd7;
  localparam logic [3:0] PH_ADDR3    = 4'd8;
  localparam logic [3:0] PH_SYNC     = 4'd9;
  localparam logic [3:0] PH_DATA     = 4'd10;

  // transfer types
  localparam logic [7:0] TT_SEND0  = 8'd0;
  localparam logic [7:0] TT_RECV1  = 8'd1;
  localparam logic [7:0] TT_SEND2  = 8'd2;
  localparam logic [7:0] TT_RECV3  = 8'd3;
  localparam logic [7:0] TT_NOP4   = 8'd4;
  localparam logic [7:0] TT_REL5   = 8'd5;
  localparam logic [7:0] TT_BSEND6 = 8'd6;
  localparam logic [7:0] TT_BRECV7 = 8'd7;

  localparam logic [7:0] HDR_ERROR  = 8'hff;
  localparam logic [7:0] ESC_FLAG   = 8'h80;
  localparam logic [7:0] ESC_BIT6   = 8'h40;
  localparam logic [31:0] SIG_MULT  = 32'd13;

endpackage

// ----- design/tube_client_protocol_engine_top.sv -----
// ----------------------------------------------------------------------------
// tube client protocol engine
// path: an accepted request enters the input register, then its result is registered with the state update
// throughput: one request per cycle while the result output is not stalled
// reset: async active low, clears both protocol machines, latches and counters
// a stalled result holds the state update and backs up into the input register
// ----------------------------------------------------------------------------
`include "tube_client_protocol_engine_top_macros.svh"

module tube_client_protocol_engine_top #(
  parameter int BLOCK_BYTES  = 256,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_ignore_incoming_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    reset_request_i,
  input  logic [2:0]              reg_address_i,
  input  logic                    is_read_i,
  input  logic [7:0]              host_byte_i,
  input  logic [7:0]              source_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              action_taken_o,
  output logic [ADDRESS_BITS-1:0] access_address_o,
  output logic [7:0]              byte_value_o,
  output logic [7:0]              event_x_o,
  output logic [7:0]              event_y_o,
  output logic [7:0]              error_code_o,
  output logic [7:0]              transfer_kind_o,
  output logic [31:0]             byte_count_o,
  output logic [31:0]             running_signature_o
);

  localparam int LeftW = $clog2(BLOCK_BYTES + 1);
  localparam logic [LeftW-1:0] LeftLoad = LeftW'(BLOCK_BYTES);

  logic                    ign_q;
  logic                    s1_valid_q;
  logic                    s1_rst_q, s1_rd_q;
  logic [2:0]              s1_addr_q;
  logic [7:0]              s1_hb_q, s1_sb_q;
  logic                    s1_fire;

  logic [1:0]              ev_q, ev_d;
  logic [3:0]              hp_q, hp_d;
  logic [7:0]              type_q, type_d;
  logic [7:0]              ex_q, ex_d, ey_q, ey_d;
  logic [7:0]              ab_q [3];
  logic [7:0]              ab_d [3];
  logic [ADDRESS_BITS-1:0] ptr_q, ptr_d;
  logic [LeftW-1:0]        left_q, left_d;
  logic [31:0]             cnt_q, cnt_d, sig_q, sig_d;
  logic [7:0]              errn_q, errn_d;

  logic                    out_valid_q;
  logic [3:0]              act;
  logic [7:0]              bval, ox, oy;
  logic [ADDRESS_BITS-1:0] aaddr;
  logic                    have_addr;
  logic                    acct;
  logic [7:0]              acct_byte;
  logic                    blk;
  logic [31:0]             sig_sum;
  logic [1:0]              ab_idx;

  logic [3:0]              act_q;
  logic [ADDRESS_BITS-1:0] aaddr_q;
  logic [7:0]              bval_q, ox_q, oy_q;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign ab_idx      = 2'(hp_q[1:0] - 2'd1);

  always_comb begin
    ev_d      = ev_q;
    hp_d      = hp_q;
    type_d    = type_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    ab_d      = ab_q;
    ptr_d     = ptr_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    sig_d     = sig_q;
    errn_d    = errn_q;
    act       = tcpe_pkg::ACT_NONE;
    bval      = 8'd0;
    ox        = 8'd0;
    oy        = 8'd0;
    aaddr     = ptr_q;
    have_addr = 1'b0;
    acct      = 1'b0;
    acct_byte = s1_hb_q;
    blk       = 1'b0;
    sig_sum   = 32'd0;

    if (s1_rst_q) begin
      ev_d = tcpe_pkg::EV_IDLE;
      hp_d = tcpe_pkg::PH_IDLE;
      act  = tcpe_pkg::ACT_RESET;
    end else if (!s1_rd_q) begin
      if (s1_addr_q == tcpe_pkg::REG_R1) begin
        unique case (ev_q)
          tcpe_pkg::EV_IDLE: begin
            if ((s1_hb_q & tcpe_pkg::ESC_FLAG) != 8'd0) begin
              act  = tcpe_pkg::ACT_ESCAPE;
              bval = s1_hb_q & tcpe_pkg::ESC_BIT6;
            end else begin
              ev_d = tcpe_pkg::EV_WAIT_Y;
            end
          end
          tcpe_pkg::EV_WAIT_Y: begin
            ey_d = s1_hb_q;
            ev_d = tcpe_pkg::EV_WAIT_X;
          end
          tcpe_pkg::EV_WAIT_X: begin
            ex_d = s1_hb_q;
            ev_d = tcpe_pkg::EV_WAIT_A;
          end
          default: begin
            act  = tcpe_pkg::ACT_EVENT;
            bval = s1_hb_q;
            ox   = ex_q;
            oy   = ey_q;
            ev_d = tcpe_pkg::EV_IDLE;
          end
        endcase
      end

      unique case (hp_q)
        tcpe_pkg::PH_ERR_ZERO: begin
          if (s1_addr_q == tcpe_pkg::REG_R2) hp_d = tcpe_pkg::PH_ERR_NUM;
        end
        tcpe_pkg::PH_ERR_NUM: begin
          if (s1_addr_q == tcpe_pkg::REG_R2) begin
            errn_d = s1_hb_q;
            hp_d   = tcpe_pkg::PH_ERR_STR;
          end
        end
        tcpe_pkg::PH_ERR_STR: begin
          if (s1_addr_q == tcpe_pkg::REG_R2) begin
            bval = s1_hb_q;
            if (s1_hb_q != 8'd0) begin
              act = tcpe_pkg::ACT_ERRCHAR;
            end else begin
              act  = tcpe_pkg::ACT_ERRDONE;
              hp_d = tcpe_pkg::PH_IDLE;
            end
          end
        end
        tcpe_pkg::PH_ID: begin
          if (s1_addr_q == tcpe_pkg::REG_R4) begin
            if (type_q == tcpe_pkg::TT_REL5) begin
              hp_d = tcpe_pkg::PH_IDLE;
              act  = tcpe_pkg::ACT_HDRDONE;
            end else begin
              hp_d = tcpe_pkg::PH_ADDR0;
            end
          end
        end
        tcpe_pkg::PH_ADDR0, tcpe_pkg::PH_ADDR1, tcpe_pkg::PH_ADDR2: begin
          if (s1_addr_q == tcpe_pkg::REG_R4) begin
            ab_d[ab_idx] = s1_hb_q;
            hp_d         = 4'(hp_q + 4'd1);
          end
        end
        tcpe_pkg::PH_ADDR3: begin
          if (s1_addr_q == tcpe_pkg::REG_R4) begin
            ptr_d = ADDRESS_BITS'({ab_q[0], ab_q[1], ab_q[2], s1_hb_q});
            hp_d  = tcpe_pkg::PH_SYNC;
          end
        end
        tcpe_pkg::PH_SYNC: begin
          if (s1_addr_q == tcpe_pkg::REG_R4) begin
            cnt_d = 32'd0;
            sig_d = 32'd0;
            if (type_q == tcpe_pkg::TT_SEND0 || type_q == tcpe_pkg::TT_SEND2 ||
                type_q == tcpe_pkg::TT_BSEND6) begin
              if (type_q == tcpe_pkg::TT_BSEND6) left_d = LeftLoad;
              hp_d      = tcpe_pkg::PH_DATA;
              act       = tcpe_pkg::ACT_SEND;
              bval      = s1_sb_q;
              have_addr = 1'b1;
              acct      = 1'b1;
              acct_byte = s1_sb_q;
            end else if (type_q == tcpe_pkg::TT_RECV1 || type_q == tcpe_pkg::TT_RECV3 ||
                         type_q == tcpe_pkg::TT_BRECV7) begin
              if (type_q == tcpe_pkg::TT_BRECV7) left_d = LeftLoad;
              hp_d = tcpe_pkg::PH_DATA;
              act  = tcpe_pkg::ACT_HDRDONE;
            end else if (type_q == tcpe_pkg::TT_NOP4 || type_q == tcpe_pkg::TT_REL5) begin
              hp_d = tcpe_pkg::PH_IDLE;
              act  = tcpe_pkg::ACT_HDRDONE;
            end else begin
              hp_d = tcpe_pkg::PH_IDLE;
              act  = tcpe_pkg::ACT_BADTYPE;
            end
          end
        end
        tcpe_pkg::PH_DATA: begin
          if (s1_addr_q == tcpe_pkg::REG_R3) begin
            blk = (type_q == tcpe_pkg::TT_BRECV7) && (left_q != '0);
            if (type_q == tcpe_pkg::TT_RECV1 || type_q == tcpe_pkg::TT_RECV3 || blk) begin
              bval = s1_hb_q;
              if (ign_q) begin
                act = tcpe_pkg::ACT_DISCARD;
              end else begin
                act       = tcpe_pkg::ACT_STORE;
                have_addr = 1'b1;
              end
              acct = 1'b1;
            end
          end else if (s1_addr_q == tcpe_pkg::REG_R4) begin
            type_d = s1_hb_q;
            hp_d   = (s1_hb_q == tcpe_pkg::HDR_ERROR) ? tcpe_pkg::PH_ERR_ZERO
                                                      : tcpe_pkg::PH_ID;
          end
        end
        default: begin
          hp_d = tcpe_pkg::PH_IDLE;
          if (s1_addr_q == tcpe_pkg::REG_R4) begin
            type_d = s1_hb_q;
            hp_d   = (s1_hb_q == tcpe_pkg::HDR_ERROR) ? tcpe_pkg::PH_ERR_ZERO
                                                      : tcpe_pkg::PH_ID;
          end
        end
      endcase
    end else begin
      if (hp_q == tcpe_pkg::PH_DATA && s1_addr_q == tcpe_pkg::REG_R3) begin
        blk = (type_q == tcpe_pkg::TT_BSEND6) && (left_q != '0);
        if (type_q == tcpe_pkg::TT_SEND0 || type_q == tcpe_pkg::TT_SEND2 || blk) begin
          act       = tcpe_pkg::ACT_SEND;
          bval      = s1_sb_q;
          have_addr = 1'b1;
          acct      = 1'b1;
          acct_byte = s1_sb_q;
        end
      end
    end

    // block countdown
    if (blk) begin
      left_d = left_q - LeftW'(1);
      if (left_d == '0) hp_d = tcpe_pkg::PH_IDLE;
    end

    // count, signature and pointer advance
    if (acct) begin
      cnt_d   = cnt_d + 32'd1;
      sig_sum = sig_d + {24'd0, acct_byte};
      sig_d   = sig_sum * tcpe_pkg::SIG_MULT;
      ptr_d   = ptr_d + ADDRESS_BITS'(1);
    end

    aaddr = have_addr ? ptr_q : ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_q <= 1'b0;
    end else if (cfg_valid_i) begin
      ign_q <= cfg_ignore_incoming_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_rst_q  <= reset_request_i;
      s1_addr_q <= reg_address_i;
      s1_rd_q   <= is_read_i;
      s1_hb_q   <= host_byte_i;
      s1_sb_q   <= source_byte_i;
    end
  end

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q   <= tcpe_pkg::EV_IDLE;
      hp_q   <= tcpe_pkg::PH_IDLE;
      type_q <= 8'd0;
      ex_q   <= 8'd0;
      ey_q   <= 8'd0;
      ab_q   <= '{default: 8'd0};
      ptr_q  <= '0;
      left_q <= '0;
      cnt_q  <= 32'd0;
      sig_q  <= 32'd0;
      errn_q <= 8'd0;
    end else if (s1_fire) begin
      ev_q   <= ev_d;
      hp_q   <= hp_d;
      type_q <= type_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      ab_q   <= ab_d;
      ptr_q  <= ptr_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
      sig_q  <= sig_d;
      errn_q <= errn_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      act_q   <= act;
      aaddr_q <= aaddr;
      bval_q  <= bval;
      ox_q    <= ox;
      oy_q    <= oy;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign action_taken_o      = act_q;
  assign access_address_o    = aaddr_q;
  assign byte_value_o        = bval_q;
  assign event_x_o           = ox_q;
  assign event_y_o           = oy_q;
  assign error_code_o        = errn_q;
  assign transfer_kind_o     = type_q;
  assign byte_count_o        = cnt_q;
  assign running_signature_o = sig_q;

  `TCPE_ASSERT_IMP(a_phase_range, clk_i, rst_ni, 1'b1, hp_q <= tcpe_pkg::PH_DATA,
                   "header phase left its legal range")
  `TCPE_ASSERT_IMP(a_left_range, clk_i, rst_ni, 1'b1, left_q <= LeftLoad,
                   "block countdown exceeds block size")
  `TCPE_ASSERT_NXT(a_fire_result, clk_i, rst_ni, s1_fire, out_valid_q,
                   "accepted request produced no result")
  `TCPE_ASSERT_IMP(a_stall_src, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_q,
                   "input stalled without a pending request")
  `TCPE_ASSERT_IMP(a_event_zero, clk_i, rst_ni,
                   out_valid_q && act_q != tcpe_pkg::ACT_EVENT,
                   ox_q == 8'd0 && oy_q == 8'd0,
                   "event bytes shown without event action")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tube client protocol engine testbench
// drives host bus cycles through the request channel and checks every result
// against a cycle-free model of both protocol machines; a short directed list
// comes first, then random escape, event, error and transfer sequences under
// both settings of ignore_incoming, with bursty requests and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int BLOCK_LEN    = 256;
  localparam int PTR_BITS     = 32;
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_LIMIT   = 5000;

  typedef struct packed {
    logic       rst;
    logic [2:0] addr;
    logic       rd;
    logic [7:0] hb;
    logic [7:0] sb;
    logic       typed;
    logic [3:0] want_act;
    logic [7:0] want_bval;
  } req_t;

  typedef struct packed {
    logic [3:0]  act;
    logic [31:0] addr;
    logic [7:0]  bval;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  err;
    logic [7:0]  kind;
    logic [31:0] count;
    logic [31:0] sig;
  } engine_result_t;

  typedef struct packed {
    engine_result_t res;
    logic           typed;
    logic [3:0]     want_act;
    logic [7:0]     want_bval;
  } pending_t;

  localparam req_t DIR_ROWS [25] = '{
    '{1'b0, tcpe_pkg::REG_R1, 1'b0, 8'h80, 8'h00, 1'b1, tcpe_pkg::ACT_ESCAPE,  8'h00},
    '{1'b0, tcpe_pkg::REG_R1, 1'b0, 8'hc0, 8'hff, 1'b1, tcpe_pkg::ACT_ESCAPE,  8'h40},
    '{1'b0, tcpe_pkg::REG_R1, 1'b0, 8'h12, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R1, 1'b0, 8'hff, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R1, 1'b0, 8'h00, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R1, 1'b0, 8'hab, 8'h00, 1'b1, tcpe_pkg::ACT_EVENT,   8'hab},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R2, 1'b0, 8'h00, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R2, 1'b0, 8'hff, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R2, 1'b0, 8'h41, 8'h00, 1'b1, tcpe_pkg::ACT_ERRCHAR, 8'h41},
    '{1'b0, tcpe_pkg::REG_R2, 1'b0, 8'h00, 8'h00, 1'b1, tcpe_pkg::ACT_ERRDONE, 8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'h05, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'h00, 8'h00, 1'b1, tcpe_pkg::ACT_HDRDONE, 8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'h00, 8'h00, 1'b0, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'h00, 1'b0, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'h00, 1'b0, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'h00, 1'b0, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'h00, 1'b0, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'h00, 1'b0, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R4, 1'b0, 8'h00, 8'hff, 1'b1, tcpe_pkg::ACT_SEND,    8'hff},
    '{1'b0, tcpe_pkg::REG_R3, 1'b1, 8'hff, 8'h00, 1'b1, tcpe_pkg::ACT_SEND,    8'h00},
    '{1'b0, tcpe_pkg::REG_R3, 1'b0, 8'h5a, 8'h77, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, tcpe_pkg::REG_R1, 1'b1, 8'h80, 8'h00, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b0, 3'd0,             1'b0, 8'hff, 8'hff, 1'b1, tcpe_pkg::ACT_NONE,    8'h00},
    '{1'b1, tcpe_pkg::REG_R4, 1'b0, 8'hff, 8'hff, 1'b1, tcpe_pkg::ACT_RESET,   8'h00}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_ignore_incoming_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic reset_request_i;
  logic [2:0] reg_address_i;
  logic is_read_i;
  logic [7:0] host_byte_i;
  logic [7:0] source_byte_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3:0] action_taken_o;
  logic [PTR_BITS-1:0] access_address_o;
  logic [7:0] byte_value_o;
  logic [7:0] event_x_o;
  logic [7:0] event_y_o;
  logic [7:0] error_code_o;
  logic [7:0] transfer_kind_o;
  logic [31:0] byte_count_o;
  logic [31:0] running_signature_o;

  req_t cur_req = '0;

  assign reset_request_i = cur_req.rst;
  assign reg_address_i   = cur_req.addr;
  assign is_read_i       = cur_req.rd;
  assign host_byte_i     = cur_req.hb;
  assign source_byte_i   = cur_req.sb;

  always #10 clk_i = ~clk_i;

  tube_client_protocol_engine_top #(
    .BLOCK_BYTES (BLOCK_LEN),
    .ADDRESS_BITS(PTR_BITS)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_ignore_incoming_i(cfg_ignore_incoming_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .reset_request_i      (reset_request_i),
    .reg_address_i        (reg_address_i),
    .is_read_i            (is_read_i),
    .host_byte_i          (host_byte_i),
    .source_byte_i        (source_byte_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .action_taken_o       (action_taken_o),
    .access_address_o     (access_address_o),
    .byte_value_o         (byte_value_o),
    .event_x_o            (event_x_o),
    .event_y_o            (event_y_o),
    .error_code_o         (error_code_o),
    .transfer_kind_o      (transfer_kind_o),
    .byte_count_o         (byte_count_o),
    .running_signature_o  (running_signature_o)
  );

  // engine model state
  logic        ignore_cfg = 1'b0;
  logic [1:0]  ev_phase = tcpe_pkg::EV_IDLE;
  logic [3:0]  hdr_phase = tcpe_pkg::PH_IDLE;
  logic [7:0]  xfer_kind = '0;
  logic [7:0]  ev_x = '0;
  logic [7:0]  ev_y = '0;
  logic [7:0]  addr_hi [3] = '{default: '0};
  logic [31:0] xfer_ptr = '0;
  logic [8:0]  blk_left = '0;
  logic [31:0] moved = '0;
  logic [31:0] sig_acc = '0;
  logic [7:0]  err_num = '0;

  req_t     stim_q [$];
  pending_t pending [$];
  int errors = 0;
  int reqs_seen = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int act_hits [16] = '{default: 0};

  function automatic void move_byte(input logic [7:0] b);
    moved   = moved + 32'd1;
    sig_acc = (sig_acc + {24'd0, b}) * tcpe_pkg::SIG_MULT;
    xfer_ptr = xfer_ptr + 32'd1;
  endfunction

  function automatic void open_header(input logic [7:0] b);
    xfer_kind = b;
    hdr_phase = (b == tcpe_pkg::HDR_ERROR) ? tcpe_pkg::PH_ERR_ZERO : tcpe_pkg::PH_ID;
  endfunction

  function automatic engine_result_t advance_engine(input req_t r);
    engine_result_t res;
    logic have_addr;
    logic blk;
    res = '0;
    have_addr = 1'b0;
    if (r.rst) begin
      ev_phase = tcpe_pkg::EV_IDLE;
      hdr_phase = tcpe_pkg::PH_IDLE;
      res.act = tcpe_pkg::ACT_RESET;
    end else if (!r.rd) begin
      if (r.addr == tcpe_pkg::REG_R1) begin
        case (ev_phase)
          tcpe_pkg::EV_IDLE: begin
            if ((r.hb & tcpe_pkg::ESC_FLAG) != 8'd0) begin
              res.act = tcpe_pkg::ACT_ESCAPE;
              res.bval = r.hb & tcpe_pkg::ESC_BIT6;
            end else begin
              ev_phase = tcpe_pkg::EV_WAIT_Y;
            end
          end
          tcpe_pkg::EV_WAIT_Y: begin
            ev_y = r.hb;
            ev_phase = tcpe_pkg::EV_WAIT_X;
          end
          tcpe_pkg::EV_WAIT_X: begin
            ev_x = r.hb;
            ev_phase = tcpe_pkg::EV_WAIT_A;
          end
          default: begin
            res.act = tcpe_pkg::ACT_EVENT;
            res.bval = r.hb;
            res.ex = ev_x;
            res.ey = ev_y;
            ev_phase = tcpe_pkg::EV_IDLE;
          end
        endcase
      end
      case (hdr_phase)
        tcpe_pkg::PH_ERR_ZERO: begin
          if (r.addr == tcpe_pkg::REG_R2) hdr_phase = tcpe_pkg::PH_ERR_NUM;
        end
        tcpe_pkg::PH_ERR_NUM: begin
          if (r.addr == tcpe_pkg::REG_R2) begin
            err_num = r.hb;
            hdr_phase = tcpe_pkg::PH_ERR_STR;
          end
        end
        tcpe_pkg::PH_ERR_STR: begin
          if (r.addr == tcpe_pkg::REG_R2) begin
            res.bval = r.hb;
            if (r.hb != 8'd0) begin
              res.act = tcpe_pkg::ACT_ERRCHAR;
            end else begin
              res.act = tcpe_pkg::ACT_ERRDONE;
              hdr_phase = tcpe_pkg::PH_IDLE;
            end
          end
        end
        tcpe_pkg::PH_ID: begin
          if (r.addr == tcpe_pkg::REG_R4) begin
            if (xfer_kind == tcpe_pkg::TT_REL5) begin
              hdr_phase = tcpe_pkg::PH_IDLE;
              res.act = tcpe_pkg::ACT_HDRDONE;
            end else begin
              hdr_phase = tcpe_pkg::PH_ADDR0;
            end
          end
        end
        tcpe_pkg::PH_ADDR0, tcpe_pkg::PH_ADDR1, tcpe_pkg::PH_ADDR2: begin
          if (r.addr == tcpe_pkg::REG_R4) begin
            addr_hi[2'(hdr_phase - tcpe_pkg::PH_ADDR0)] = r.hb;
            hdr_phase = hdr_phase + 4'd1;
          end
        end
        tcpe_pkg::PH_ADDR3: begin
          if (r.addr == tcpe_pkg::REG_R4) begin
            xfer_ptr = {addr_hi[0], addr_hi[1], addr_hi[2], r.hb};
            hdr_phase = tcpe_pkg::PH_SYNC;
          end
        end
        tcpe_pkg::PH_SYNC: begin
          if (r.addr == tcpe_pkg::REG_R4) begin
            moved = '0;
            sig_acc = '0;
            case (xfer_kind)
              tcpe_pkg::TT_SEND0, tcpe_pkg::TT_SEND2, tcpe_pkg::TT_BSEND6: begin
                if (xfer_kind == tcpe_pkg::TT_BSEND6) blk_left = 9'(BLOCK_LEN);
                hdr_phase = tcpe_pkg::PH_DATA;
                res.act = tcpe_pkg::ACT_SEND;
                res.bval = r.sb;
                res.addr = xfer_ptr;
                have_addr = 1'b1;
                move_byte(r.sb);
              end
              tcpe_pkg::TT_RECV1, tcpe_pkg::TT_RECV3, tcpe_pkg::TT_BRECV7: begin
                if (xfer_kind == tcpe_pkg::TT_BRECV7) blk_left = 9'(BLOCK_LEN);
                hdr_phase = tcpe_pkg::PH_DATA;
                res.act = tcpe_pkg::ACT_HDRDONE;
              end
              tcpe_pkg::TT_NOP4, tcpe_pkg::TT_REL5: begin
                hdr_phase = tcpe_pkg::PH_IDLE;
                res.act = tcpe_pkg::ACT_HDRDONE;
              end
              default: begin
                hdr_phase = tcpe_pkg::PH_IDLE;
                res.act = tcpe_pkg::ACT_BADTYPE;
              end
            endcase
          end
        end
        tcpe_pkg::PH_DATA: begin
          if (r.addr == tcpe_pkg::REG_R3) begin
            blk = (xfer_kind == tcpe_pkg::TT_BRECV7) && (blk_left != 9'd0);
            if (xfer_kind == tcpe_pkg::TT_RECV1 || xfer_kind == tcpe_pkg::TT_RECV3 || blk) begin
              res.bval = r.hb;
              if (ignore_cfg) begin
                res.act = tcpe_pkg::ACT_DISCARD;
              end else begin
                res.act = tcpe_pkg::ACT_STORE;
                res.addr = xfer_ptr;
                have_addr = 1'b1;
              end
              move_byte(r.hb);
            end
            if (blk) begin
              blk_left = blk_left - 9'd1;
              if (blk_left == 9'd0) hdr_phase = tcpe_pkg::PH_IDLE;
            end
          end else if (r.addr == tcpe_pkg::REG_R4) begin
            open_header(r.hb);
          end
        end
        default: begin
          hdr_phase = tcpe_pkg::PH_IDLE;
          if (r.addr == tcpe_pkg::REG_R4) open_header(r.hb);
        end
      endcase
    end else if (hdr_phase == tcpe_pkg::PH_DATA && r.addr == tcpe_pkg::REG_R3) begin
      blk = (xfer_kind == tcpe_pkg::TT_BSEND6) && (blk_left != 9'd0);
      if (xfer_kind == tcpe_pkg::TT_SEND0 || xfer_kind == tcpe_pkg::TT_SEND2 || blk) begin
        res.act = tcpe_pkg::ACT_SEND;
        res.bval = r.sb;
        res.addr = xfer_ptr;
        have_addr = 1'b1;
        move_byte(r.sb);
      end
      if (blk) begin
        blk_left = blk_left - 9'd1;
        if (blk_left == 9'd0) hdr_phase = tcpe_pkg::PH_IDLE;
      end
    end
    if (!have_addr) res.addr = xfer_ptr;
    res.err = err_num;
    res.kind = xfer_kind;
    res.count = moved;
    res.sig = sig_acc;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns %s mismatch: expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // result checking, model update and watchdog
  always @(posedge clk_i) begin
    pending_t p;
    logic busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        results_seen++;
        act_hits[action_taken_o]++;
        if (pending.size() == 0) begin
          $display("%0t ns unexpected result: action %0d", $time, action_taken_o);
          errors++;
        end else begin
          p = pending.pop_front();
          if (p.typed) begin
            check_field("listed action", 32'(p.want_act), 32'(action_taken_o));
            check_field("listed byte_value", 32'(p.want_bval), 32'(byte_value_o));
          end
          check_field("action_taken", 32'(p.res.act), 32'(action_taken_o));
          check_field("access_address", p.res.addr, access_address_o);
          check_field("byte_value", 32'(p.res.bval), 32'(byte_value_o));
          check_field("event_x", 32'(p.res.ex), 32'(event_x_o));
          check_field("event_y", 32'(p.res.ey), 32'(event_y_o));
          check_field("error_code", 32'(p.res.err), 32'(error_code_o));
          check_field("transfer_kind", 32'(p.res.kind), 32'(transfer_kind_o));
          check_field("byte_count", p.res.count, byte_count_o);
          check_field("running_signature", p.res.sig, running_signature_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        busy = 1'b1;
        ignore_cfg = cfg_ignore_incoming_i;
        cfg_writes++;
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        reqs_seen++;
        p.res = advance_engine(cur_req);
        p.typed = cur_req.typed;
        p.want_act = cur_req.want_act;
        p.want_bval = cur_req.want_bval;
        pending.push_back(p);
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("tube_client_protocol_engine_top regression: fail");
      $finish;
    end
  end

  // output stall pattern
  initial begin
    int mode;
    int len;
    int k;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(16, 160);
      for (k = 0; k < len; k++) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (k % 4) != 3;
          default: out_ready_i <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic add_req(input logic rst, input logic [2:0] a, input logic rd,
                         input logic [7:0] hb, input logic [7:0] sb);
    req_t r;
    r = '0;
    r.rst = rst;
    r.addr = a;
    r.rd = rd;
    r.hb = hb;
    r.sb = sb;
    stim_q.push_back(r);
  endtask

  task automatic add_noise();
    add_req($urandom_range(0, 15) == 0, 3'($urandom), 1'($urandom), 8'($urandom),
            8'($urandom));
  endtask

  task automatic add_transfer(input logic [7:0] kind, input int n, input bit clean);
    logic sends;
    logic wrong;
    int i;
    sends = (kind == tcpe_pkg::TT_SEND0 || kind == tcpe_pkg::TT_SEND2 ||
             kind == tcpe_pkg::TT_BSEND6);
    add_req(1'b0, tcpe_pkg::REG_R4, 1'b0, kind, 8'($urandom));
    add_req(1'b0, tcpe_pkg::REG_R4, 1'b0, 8'($urandom), 8'($urandom));
    if (kind == tcpe_pkg::TT_REL5 && $urandom_range(0, 3) != 0) return;
    repeat (4) begin
      add_req(1'b0, tcpe_pkg::REG_R4, 1'b0,
              ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom), 8'($urandom));
    end
    add_req(1'b0, tcpe_pkg::REG_R4, 1'b0, 8'($urandom), 8'($urandom));
    for (i = 0; i < n; i++) begin
      if (!clean && $urandom_range(0, 11) == 0) begin
        add_req(1'b0, tcpe_pkg::REG_R1, 1'b0, 8'($urandom), 8'($urandom));
      end
      wrong = !clean && ($urandom_range(0, 9) == 0);
      add_req(1'b0, tcpe_pkg::REG_R3, sends ^ wrong, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic add_random(input int n);
    int start;
    int pick;
    logic [7:0] kind;
    start = stim_q.size();
    while (stim_q.size() < start + n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        kind = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        add_transfer(kind, $urandom_range(0, 10), 1'b0);
      end else if (pick < 55) begin
        add_req(1'b0, tcpe_pkg::REG_R1, 1'b0, {1'b0, 7'($urandom)}, 8'($urandom));
        repeat (3) add_req(1'b0, tcpe_pkg::REG_R1, 1'b0, 8'($urandom), 8'($urandom));
      end else if (pick < 63) begin
        add_req(1'b0, tcpe_pkg::REG_R1, 1'b0, {1'b1, 7'($urandom)}, 8'($urandom));
      end else if (pick < 75) begin
        add_req(1'b0, tcpe_pkg::REG_R4, 1'b0, tcpe_pkg::HDR_ERROR, 8'($urandom));
        add_req(1'b0, tcpe_pkg::REG_R2, 1'b0, 8'($urandom), 8'($urandom));
        add_req(1'b0, tcpe_pkg::REG_R2, 1'b0, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 6)) begin
          add_req(1'b0, tcpe_pkg::REG_R2, 1'b0, 8'($urandom_range(1, 255)), 8'($urandom));
        end
        add_req(1'b0, tcpe_pkg::REG_R2, 1'b0, 8'h00, 8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) add_noise();
      end else begin
        // header cut short, then a stray cycle
        add_req(1'b0, tcpe_pkg::REG_R4, 1'b0, 8'($urandom_range(0, 7)), 8'($urandom));
        repeat ($urandom_range(0, 5)) begin
          add_req(1'b0, tcpe_pkg::REG_R4, 1'b0, 8'($urandom), 8'($urandom));
        end
        add_noise();
      end
    end
  endtask

  task automatic drive_all();
    int burst;
    int gap;
    while (stim_q.size() != 0) begin
      burst = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
      while (burst > 0 && stim_q.size() != 0) begin
        cur_req <= stim_q.pop_front();
        in_valid_i <= 1'b1;
        do @(posedge clk_i); while (!in_ready_o);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0 || stim_q.size() == 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ignore(input logic v);
    wait_drained();
    cfg_ignore_incoming_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int ph;
    int seen;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIR_ROWS[i]) stim_q.push_back(DIR_ROWS[i]);
    drive_all();
    for (ph = 0; ph < 4; ph++) begin
      write_ignore(ph % 2 == 0);
      // full blocks run past their length so the extra cycles must be ignored
      if (ph == 0) add_transfer(tcpe_pkg::TT_BRECV7, BLOCK_LEN + 2, 1'b1);
      if (ph == 1) add_transfer(tcpe_pkg::TT_BSEND6, BLOCK_LEN + 3, 1'b1);
      add_random(210);
      drive_all();
    end
    wait_drained();
    if (reqs_seen != results_seen) begin
      $display("%0t ns result count: expected %0d, got %0d", $time, reqs_seen, results_seen);
      errors++;
    end
    seen = 0;
    foreach (act_hits[i]) if (act_hits[i] != 0) seen++;
    $display("covered %0d host cycles, %0d results checked, %0d ignore_incoming writes",
             reqs_seen, results_seen, cfg_writes);
    $display("%0d distinct action codes observed, %0d mismatches", seen, errors);
    if (errors == 0) begin
      $display("tube_client_protocol_engine_top regression: pass");
    end else begin
      $display("tube_client_protocol_engine_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tcpe_pkg.sv
design/tube_client_protocol_engine_top.sv
tb/tb_top.sv
